// File: rtl/ptafb_pkg.sv
// Package for the periodic tilt / acceleration frame broadcaster.
// Holds the shared code types, configuration register indexes and scaling constants.
// No dependencies.
package ptafb_pkg;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BROADCAST_ENABLE = 3'd0,
    CFG_ANGLE_RATE       = 3'd1,
    CFG_ANGLE_FRAME_TYPE = 3'd2,
    CFG_ANGLE_FRAME_ID   = 3'd3,
    CFG_ACCEL_RATE       = 3'd4,
    CFG_ACCEL_FRAME_TYPE = 3'd5,
    CFG_ACCEL_FRAME_ID   = 3'd6
  } cfg_reg_t;

  localparam int CfgDataW = 29;
  localparam int RateW    = 16;
  localparam int TypeW    = 8;
  localparam int IdW      = 29;
  localparam int SampleW  = 16;
  localparam int PayloadW = 64;

  // Frame kind codes.
  localparam logic FRAME_ANGLE = 1'b0;
  localparam logic FRAME_ACCEL = 1'b1;

  // Angle clamp window, offset and gain.
  localparam logic signed [SampleW-1:0] ANGLE_LO     = -16'sd6400;
  localparam logic signed [SampleW-1:0] ANGLE_HI     = 16'sd6451;
  localparam logic        [SampleW-1:0] ANGLE_OFFSET = 16'd6400;
  localparam logic        [17:0]        ANGLE_GAIN   = 18'd5;

  // Acceleration clamp window, offset and divide-by-ten reciprocal.
  localparam logic signed [SampleW-1:0] ACCEL_LO     = -16'sd1250;
  localparam logic signed [SampleW-1:0] ACCEL_HI     = 16'sd1250;
  localparam logic        [SampleW-1:0] ACCEL_OFFSET = 16'd1250;
  localparam logic        [27:0]        DIV10_RECIP  = 28'd52429;
  localparam int                        DIV10_SHIFT  = 19;

  // Filler for unused payload bytes.
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Scaled codes of one tick.
  typedef struct packed {
    logic [15:0] pitch_code;
    logic [15:0] roll_code;
    logic [7:0]  accel_code;
  } ptafb_codes_t;

endpackage

// File: rtl/periodic_tilt_accel_frame_broadcaster.sv
// Top level of the periodic tilt / acceleration frame broadcaster.
// Holds configuration, tick counters and the frame output stage; uses ptafb_pkg
// and ptafb_scale.
//
// Usage:
//   Each input transaction is one 1 ms tick carrying roll, pitch, longitudinal
//   acceleration and a task enable. When broadcast_enable and the task enable are
//   both set, both tick counters advance; a counter that reaches its rate register
//   clears and yields one frame. A tick gives zero, one or two output transactions,
//   the angle frame first; out_last_of_tick marks the final frame of a tick.
//   Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at the
//   clock edge; the user issues them only while no frames are pending, and the
//   block itself does not enforce this.
// Timing and throughput:
//   Frames of a tick appear in the cycle after the tick is accepted. The output
//   stage sends one frame per cycle while out_ready is high; a new tick is taken
//   in the same cycle the last pending frame of the previous one leaves.
// Reset and stalls:
//   Synchronous active-low reset clears all configuration, both counters and the
//   pending frames. While out_ready is low, pending frames hold and in_ready drops
//   until at most one frame remains and is being taken.
module periodic_tilt_accel_frame_broadcaster (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_write_en,
  input  logic [2:0]  cfg_index,
  input  logic [28:0] cfg_data,
  // Tick input channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_roll_angle,
  input  logic signed [15:0] in_pitch_angle,
  input  logic signed [15:0] in_longitudinal_accel,
  input  logic        in_task_enabled,
  // Frame output channel.
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_kind,
  output logic [7:0]  out_frame_type,
  output logic [28:0] out_frame_id,
  output logic [63:0] out_payload,
  output logic        out_last_of_tick
);
  import ptafb_pkg::*;

  // Configuration registers.
  logic        broadcast_enable_r;
  logic [15:0] angle_rate_r;
  logic [7:0]  angle_frame_type_r;
  logic [28:0] angle_frame_id_r;
  logic [15:0] accel_rate_r;
  logic [7:0]  accel_frame_type_r;
  logic [28:0] accel_frame_id_r;

  // Tick counters.
  logic [15:0] angle_cnt_r, angle_cnt_nxt;
  logic [15:0] accel_cnt_r, accel_cnt_nxt;

  // Pending frame stage.
  logic         angle_pend_r, angle_pend_nxt;
  logic         accel_pend_r, accel_pend_nxt;
  ptafb_codes_t codes_r;

  ptafb_codes_t codes;
  logic         in_fire;
  logic         out_fire;
  logic         tick_en;
  logic [15:0]  angle_inc;
  logic [15:0]  accel_inc;
  logic         angle_hit;
  logic         accel_hit;

  ptafb_scale u_scale (
    .roll_angle         (in_roll_angle),
    .pitch_angle        (in_pitch_angle),
    .longitudinal_accel (in_longitudinal_accel),
    .codes              (codes)
  );

  // Configuration register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      broadcast_enable_r <= 1'b0;
      angle_rate_r       <= '0;
      angle_frame_type_r <= '0;
      angle_frame_id_r   <= '0;
      accel_rate_r       <= '0;
      accel_frame_type_r <= '0;
      accel_frame_id_r   <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_BROADCAST_ENABLE: broadcast_enable_r <= cfg_data[0];
        CFG_ANGLE_RATE:       angle_rate_r       <= cfg_data[15:0];
        CFG_ANGLE_FRAME_TYPE: angle_frame_type_r <= cfg_data[7:0];
        CFG_ANGLE_FRAME_ID:   angle_frame_id_r   <= cfg_data;
        CFG_ACCEL_RATE:       accel_rate_r       <= cfg_data[15:0];
        CFG_ACCEL_FRAME_TYPE: accel_frame_type_r <= cfg_data[7:0];
        CFG_ACCEL_FRAME_ID:   accel_frame_id_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshakes: accept a tick once at most one frame is left and it is leaving.
  assign out_valid = angle_pend_r | accel_pend_r;
  assign out_fire  = out_valid & out_ready;
  assign in_ready  = ~out_valid | (out_ready & (angle_pend_r ^ accel_pend_r));
  assign in_fire   = in_valid & in_ready;
  assign tick_en   = broadcast_enable_r & in_task_enabled;

  // Counter advance and rate match.
  always_comb begin
    angle_inc     = angle_cnt_r + 16'd1;
    accel_inc     = accel_cnt_r + 16'd1;
    angle_hit     = (angle_inc == angle_rate_r);
    accel_hit     = (accel_inc == accel_rate_r);
    angle_cnt_nxt = angle_cnt_r;
    accel_cnt_nxt = accel_cnt_r;
    if (in_fire && tick_en) begin
      angle_cnt_nxt = angle_hit ? 16'd0 : angle_inc;
      accel_cnt_nxt = accel_hit ? 16'd0 : accel_inc;
    end
  end

  // Pending flags: load on a new tick, otherwise retire the angle frame first.
  always_comb begin
    angle_pend_nxt = angle_pend_r;
    accel_pend_nxt = accel_pend_r;
    if (out_fire) begin
      if (angle_pend_r) begin
        angle_pend_nxt = 1'b0;
      end else begin
        accel_pend_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      angle_pend_nxt = tick_en & angle_hit;
      accel_pend_nxt = tick_en & accel_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_cnt_r  <= '0;
      accel_cnt_r  <= '0;
      angle_pend_r <= 1'b0;
      accel_pend_r <= 1'b0;
    end else begin
      angle_cnt_r  <= angle_cnt_nxt;
      accel_cnt_r  <= accel_cnt_nxt;
      angle_pend_r <= angle_pend_nxt;
      accel_pend_r <= accel_pend_nxt;
    end
  end

  // Code register carries no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      codes_r <= codes;
    end
  end

  // Output frame selection.
  always_comb begin
    if (angle_pend_r) begin
      out_frame_kind = FRAME_ANGLE;
      out_frame_type = angle_frame_type_r;
      out_frame_id   = angle_frame_id_r;
      out_payload    = {{4{FILL_BYTE}}, codes_r.roll_code, codes_r.pitch_code};
    end else begin
      out_frame_kind = FRAME_ACCEL;
      out_frame_type = accel_frame_type_r;
      out_frame_id   = accel_frame_id_r;
      out_payload    = {codes_r.accel_code, {7{FILL_BYTE}}};
    end
    out_last_of_tick = ~(angle_pend_r & accel_pend_r);
  end

  // A disabled tick leaves nothing to send.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !tick_en) |=> !out_valid)
    else $error("frame pending after a disabled tick");

  // Only the angle frame can precede another frame of the same tick.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_of_tick) |-> (out_frame_kind == FRAME_ANGLE))
    else $error("non-final frame is not an angle frame");

  // No new tick while two frames are still pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (angle_pend_r && accel_pend_r) |-> !in_ready)
    else $error("tick accepted with two frames pending");

  // Counters move only when a tick is accepted.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) |=> ($stable(angle_cnt_r) && $stable(accel_cnt_r)))
    else $error("tick counter changed without a tick");

endmodule

// File: rtl/ptafb_scale.sv
// Clamp and scale of the tilt angles and the longitudinal acceleration.
// Purely combinational; depends on ptafb_pkg.
module ptafb_scale (
  input  logic signed [15:0]  roll_angle,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  longitudinal_accel,
  output ptafb_pkg::ptafb_codes_t codes
);
  import ptafb_pkg::*;

  logic signed [15:0] roll_clamped;
  logic signed [15:0] pitch_clamped;
  logic signed [15:0] accel_clamped;
  logic [15:0]        roll_shifted;
  logic [15:0]        pitch_shifted;
  logic [11:0]        accel_shifted;
  logic [17:0]        roll_prod;
  logic [17:0]        pitch_prod;
  logic [27:0]        accel_prod;

  // Saturate each sample to its window.
  always_comb begin
    if (roll_angle >= ANGLE_HI) begin
      roll_clamped = ANGLE_HI;
    end else if (roll_angle <= ANGLE_LO) begin
      roll_clamped = ANGLE_LO;
    end else begin
      roll_clamped = roll_angle;
    end

    if (pitch_angle >= ANGLE_HI) begin
      pitch_clamped = ANGLE_HI;
    end else if (pitch_angle <= ANGLE_LO) begin
      pitch_clamped = ANGLE_LO;
    end else begin
      pitch_clamped = pitch_angle;
    end

    if (longitudinal_accel >= ACCEL_HI) begin
      accel_clamped = ACCEL_HI;
    end else if (longitudinal_accel <= ACCEL_LO) begin
      accel_clamped = ACCEL_LO;
    end else begin
      accel_clamped = longitudinal_accel;
    end
  end

  // Shift to zero-based values; the angle range fits 14 bits, acceleration 12 bits.
  always_comb begin
    logic [15:0] accel_sum;
    roll_shifted  = 16'(roll_clamped) + ANGLE_OFFSET;
    pitch_shifted = 16'(pitch_clamped) + ANGLE_OFFSET;
    accel_sum     = 16'(accel_clamped) + ACCEL_OFFSET;
    accel_shifted = accel_sum[11:0];
  end

  // Angles scale by five; acceleration divides by ten through a reciprocal multiply.
  always_comb begin
    roll_prod        = 18'(roll_shifted) * ANGLE_GAIN;
    pitch_prod       = 18'(pitch_shifted) * ANGLE_GAIN;
    accel_prod       = 28'(accel_shifted) * DIV10_RECIP;
    codes.roll_code  = roll_prod[15:0];
    codes.pitch_code = pitch_prod[15:0];
    codes.accel_code = accel_prod[DIV10_SHIFT+7:DIV10_SHIFT];
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for periodic_tilt_accel_frame_broadcaster.
// Random ticks, random idling and configuration sweeps; frames are predicted by a scoreboard
// class and checked in order. Depends on ptafb_pkg and the broadcaster RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptafb_pkg::*;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 12;
  // Nothing may go quiet this long; the longest legal quiet stretch is the receiver hold-off.
  localparam int QuietLimit    = 2000;
  localparam int HoldOffCycles = 300;
  // Frames leave from registers loaded by their tick; this settle covers anything in flight.
  localparam int SettleCycles  = 4;
  localparam int MaxWait       = 16;
  localparam int MaxPrinted    = 100;

  // Index that maps to no register; writes to it must be dropped.
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 3'd7;

  // Scaling of the angle and acceleration codes.
  localparam int AngleMin  = -6400;
  localparam int AngleMax  = 6451;
  localparam int AngleGain = 5;
  localparam int AccelMin  = -1250;
  localparam int AccelMax  = 1250;
  localparam int AccelStep = 10;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] accel;
    logic               task_en;
  } tick_t;

  typedef struct {
    logic        kind;
    logic [7:0]  ftype;
    logic [28:0] id;
    logic [63:0] payload;
    logic        last;
  } frame_t;

  typedef struct {
    logic        en;
    logic [15:0] angle_rate;
    logic [7:0]  angle_type;
    logic [28:0] angle_id;
    logic [15:0] accel_rate;
    logic [7:0]  accel_type;
    logic [28:0] accel_id;
  } setting_t;

  // Tracks the broadcaster's registers and tick counters and holds the frames still owed.
  class tilt_frame_board;
    logic        en;
    logic [15:0] angle_rate, accel_rate;
    logic [7:0]  angle_type, accel_type;
    logic [28:0] angle_id, accel_id;
    logic [15:0] angle_count, accel_count;
    frame_t      owed_frames[$];
    int unsigned errors;

    function new();
      en          = 1'b0;
      angle_rate  = '0;
      accel_rate  = '0;
      angle_type  = '0;
      accel_type  = '0;
      angle_id    = '0;
      accel_id    = '0;
      angle_count = '0;
      accel_count = '0;
      errors      = 0;
    endfunction

    // Prints one line per mismatch; past a cap it only counts.
    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("ERROR at %0t: %s", $time, msg);
    endtask

    static function logic [15:0] angle_code(logic signed [15:0] v);
      int c;
      c = v;
      if (c >= AngleMax) c = AngleMax;
      else if (c <= AngleMin) c = AngleMin;
      return 16'((c - AngleMin) * AngleGain);
    endfunction

    static function logic [7:0] accel_code(logic signed [15:0] v);
      int c;
      c = v;
      if (c >= AccelMax) c = AccelMax;
      else if (c <= AccelMin) c = AccelMin;
      return 8'((c - AccelMin) / AccelStep);
    endfunction

    // Register write; narrower registers keep only their low bits.
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_BROADCAST_ENABLE: en = data[0];
        CFG_ANGLE_RATE:       angle_rate = data[15:0];
        CFG_ANGLE_FRAME_TYPE: angle_type = data[7:0];
        CFG_ANGLE_FRAME_ID:   angle_id = data;
        CFG_ACCEL_RATE:       accel_rate = data[15:0];
        CFG_ACCEL_FRAME_TYPE: accel_type = data[7:0];
        CFG_ACCEL_FRAME_ID:   accel_id = data;
        default: ;
      endcase
    endfunction

    // Advances the counters for one accepted tick and queues the frames it owes.
    function void take_tick(tick_t t);
      frame_t f;
      bit     angle_due, accel_due;
      if (!en || !t.task_en) return;
      angle_count = angle_count + 16'd1;
      angle_due   = (angle_count == angle_rate);
      if (angle_due) angle_count = '0;
      accel_count = accel_count + 16'd1;
      accel_due   = (accel_count == accel_rate);
      if (accel_due) accel_count = '0;
      if (angle_due) begin
        f.kind    = FRAME_ANGLE;
        f.ftype   = angle_type;
        f.id      = angle_id;
        f.payload = {{4{FILL_BYTE}}, angle_code(t.roll), angle_code(t.pitch)};
        f.last    = !accel_due;
        owed_frames.push_back(f);
      end
      if (accel_due) begin
        f.kind    = FRAME_ACCEL;
        f.ftype   = accel_type;
        f.id      = accel_id;
        f.payload = {accel_code(t.accel), {7{FILL_BYTE}}};
        f.last    = 1'b1;
        owed_frames.push_back(f);
      end
    endfunction

    // Compares a received frame against the oldest owed one, field by field.
    task compare_frame(frame_t got);
      frame_t want;
      if (owed_frames.size() == 0) begin
        report($sformatf("frame kind %0d id %h arrived with none owed", got.kind, got.id));
        return;
      end
      want = owed_frames.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("frame_kind got %b want %b", got.kind, want.kind));
      if (got.ftype !== want.ftype)
        report($sformatf("frame_type got %h want %h", got.ftype, want.ftype));
      if (got.id !== want.id)
        report($sformatf("frame_id got %h want %h", got.id, want.id));
      if (got.payload !== want.payload)
        report($sformatf("payload got %h want %h", got.payload, want.payload));
      if (got.last !== want.last)
        report($sformatf("last_of_tick got %b want %b", got.last, want.last));
    endtask

    task flag_leftovers();
      while (owed_frames.size() != 0) begin
        report($sformatf("frame kind %0d never arrived", owed_frames[0].kind));
        void'(owed_frames.pop_front());
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_write_en;
  logic [2:0]  cfg_index;
  logic [28:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic signed [15:0] in_roll_angle;
  logic signed [15:0] in_pitch_angle;
  logic signed [15:0] in_longitudinal_accel;
  logic        in_task_enabled;
  logic        out_valid;
  logic        out_ready;
  logic        out_frame_kind;
  logic [7:0]  out_frame_type;
  logic [28:0] out_frame_id;
  logic [63:0] out_payload;
  logic        out_last_of_tick;

  tilt_frame_board board = new();
  bit              sender_idles = 1'b0;
  bit              receiver_idles = 1'b0;
  bit              hold_off_request = 1'b0;
  int unsigned     quiet_cycles = 0;

  periodic_tilt_accel_frame_broadcaster dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_write_en          (cfg_write_en),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_roll_angle         (in_roll_angle),
    .in_pitch_angle        (in_pitch_angle),
    .in_longitudinal_accel (in_longitudinal_accel),
    .in_task_enabled       (in_task_enabled),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_frame_kind        (out_frame_kind),
    .out_frame_type        (out_frame_type),
    .out_frame_id          (out_frame_id),
    .out_payload           (out_payload),
    .out_last_of_tick      (out_last_of_tick)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic int unsigned draw_wait(bit idles);
    return idles ? $urandom_range(0, MaxWait) : 0;
  endfunction

  function automatic tick_t make_tick(int roll, int pitch, int accel, bit task_en);
    tick_t t;
    t.roll    = 16'(roll);
    t.pitch   = 16'(pitch);
    t.accel   = 16'(accel);
    t.task_en = task_en;
    return t;
  endfunction

  // Half the ticks span the full 16-bit range, half sit around the clamp windows.
  function automatic tick_t rand_tick(bit force_enable);
    tick_t t;
    if ($urandom_range(0, 1) == 1) begin
      t.roll  = 16'($urandom);
      t.pitch = 16'($urandom);
      t.accel = 16'($urandom);
    end else begin
      t.roll  = 16'(int'($urandom_range(0, 13200)) - 6600);
      t.pitch = 16'(int'($urandom_range(0, 13200)) - 6600);
      t.accel = 16'(int'($urandom_range(0, 2800)) - 1400);
    end
    t.task_en = force_enable || ($urandom_range(0, 7) != 0);
    return t;
  endfunction

  function automatic logic [15:0] pick_rate();
    return ($urandom_range(0, 3) == 0) ? 16'd1 : 16'($urandom_range(1, 6));
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [28:0] pick_id();
    case ($urandom_range(0, 3))
      0:       return 29'h0;
      1:       return 29'h1FFF_FFFF;
      default: return 29'($urandom);
    endcase
  endfunction

  // One register write; the caller lowers the write enable after its last write.
  task automatic drive_cfg(input logic [2:0] idx, input logic [28:0] data);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= data;
    @(posedge clk);
    board.write_reg(idx, data);
  endtask

  // Writes every register, junk above each narrow one's width, then pokes the unused index.
  task automatic apply_setting(input setting_t s);
    logic [28:0] junk;
    junk = 29'($urandom);
    drive_cfg(CFG_BROADCAST_ENABLE, {junk[28:1], s.en});
    drive_cfg(CFG_ANGLE_RATE, {junk[28:16], s.angle_rate});
    drive_cfg(CFG_ANGLE_FRAME_TYPE, {junk[28:8], s.angle_type});
    drive_cfg(CFG_ANGLE_FRAME_ID, s.angle_id);
    junk = 29'($urandom);
    drive_cfg(CFG_ACCEL_RATE, {junk[28:16], s.accel_rate});
    drive_cfg(CFG_ACCEL_FRAME_TYPE, {junk[28:8], s.accel_type});
    drive_cfg(CFG_ACCEL_FRAME_ID, s.accel_id);
    drive_cfg(CfgUnusedIdx, 29'($urandom));
    cfg_write_en <= 1'b0;
  endtask

  // Offers one tick after an optional gap and returns at the edge that accepts it.
  task automatic send_tick(input tick_t t, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid              <= 1'b1;
    in_roll_angle         <= t.roll;
    in_pitch_angle        <= t.pitch;
    in_longitudinal_accel <= t.accel;
    in_task_enabled       <= t.task_en;
    do @(posedge clk); while (!in_ready);
    board.take_tick(t);
  endtask

  // Stops offering, waits for every owed frame, then lets the pipeline settle.
  task automatic drain_frames();
    in_valid <= 1'b0;
    while (board.owed_frames.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic run_ticks(input int unsigned count, input bit force_enable);
    for (int unsigned i = 0; i < count; i++)
      send_tick(rand_tick(force_enable), draw_wait(sender_idles));
    drain_frames();
  endtask

  // Frame receiver: random back-pressure, plus one long hold-off on request.
  initial begin : frame_sink
    frame_t      got;
    int unsigned wait_cycles;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      wait_cycles = draw_wait(receiver_idles);
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind    = out_frame_kind;
      got.ftype   = out_frame_type;
      got.id      = out_frame_id;
      got.payload = out_payload;
      got.last    = out_last_of_tick;
      board.compare_frame(got);
    end
  end

  // Watchdog: any transaction or register write restarts the quiet count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Watchdog: no transaction for %0d cycles", QuietLimit);
      $display("** periodic_tilt_accel_frame_broadcaster: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    setting_t s;
    tick_t    directed[$];
    rst_n                 <= 1'b0;
    cfg_write_en          <= 1'b0;
    cfg_index             <= '0;
    cfg_data              <= '0;
    in_valid              <= 1'b0;
    in_roll_angle         <= '0;
    in_pitch_angle        <= '0;
    in_longitudinal_accel <= '0;
    in_task_enabled       <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset broadcasting is off, so these ticks yield nothing.
    run_ticks(3, 1'b1);

    // Directed ticks: field extremes, clamp edges, truncation and disabled tasks.
    directed.push_back(make_tick(-32768, 32767, -32768, 1'b1));
    directed.push_back(make_tick(32767, -32768, 32767, 1'b1));
    directed.push_back(make_tick(-6400, -6401, -1250, 1'b1));
    directed.push_back(make_tick(-6401, -6400, -1251, 1'b1));
    directed.push_back(make_tick(6451, 6452, 1250, 1'b1));
    directed.push_back(make_tick(6452, 6451, 1251, 1'b1));
    directed.push_back(make_tick(6450, -6399, 1249, 1'b1));
    directed.push_back(make_tick(0, -1, -1241, 1'b1));
    directed.push_back(make_tick(-1, 0, -1240, 1'b1));
    directed.push_back(make_tick(1234, -4321, 5, 1'b1));
    directed.push_back(make_tick(100, 200, -5, 1'b0));
    directed.push_back(make_tick(-32768, -32768, -32768, 1'b0));
    directed.push_back(make_tick(32767, 32767, 32767, 1'b1));
    directed.push_back(make_tick(0, 0, 0, 1'b1));
    directed.push_back(make_tick(-2, 2, 9, 1'b1));
    directed.push_back(make_tick(6451, -6400, 1250, 1'b1));
    s.en         = 1'b1;
    s.angle_rate = 16'd1;
    s.angle_type = 8'hFF;
    s.angle_id   = 29'h1FFF_FFFF;
    s.accel_rate = 16'd2;
    s.accel_type = 8'h00;
    s.accel_id   = 29'h0;
    apply_setting(s);
    foreach (directed[i]) send_tick(directed[i], 0);
    drain_frames();

    // Broadcasting off: counters must hold across these ticks.
    s = '{en: 1'b0, angle_rate: 16'd1, angle_type: 8'h5A, angle_id: 29'h0ABC_DEF0,
          accel_rate: 16'd1, accel_type: 8'hA5, accel_id: 29'h1234_5678};
    apply_setting(s);
    run_ticks(40, 1'b0);

    // Random phases with fresh settings and idling patterns.
    for (int phase = 0; phase < 8; phase++) begin
      s.en         = 1'b1;
      s.angle_rate = pick_rate();
      s.angle_type = pick_type();
      s.angle_id   = pick_id();
      s.accel_rate = pick_rate();
      s.accel_type = pick_type();
      s.accel_id   = pick_id();
      sender_idles   = (phase != 0) && ($urandom_range(0, 2) != 0);
      receiver_idles = (phase != 0) && ($urandom_range(0, 2) != 0);
      if (phase == 3) begin
        // Enabled ticks owe two frames while the receiver holds off, so the block backs up.
        s.angle_rate     = 16'd1;
        s.accel_rate     = 16'd1;
        sender_idles     = 1'b0;
        hold_off_request = 1'b1;
      end
      apply_setting(s);
      run_ticks(130, 1'b0);
    end

    // Rate extremes: zero and the maximum rate both stay silent over a short run.
    s.en             = 1'b1;
    s.angle_rate     = 16'd0;
    s.accel_rate     = 16'hFFFF;
    sender_idles     = 1'b0;
    receiver_idles   = 1'b0;
    apply_setting(s);
    run_ticks(100, 1'b1);

    board.flag_leftovers();
    if (board.errors == 0) begin
      $display("** periodic_tilt_accel_frame_broadcaster: PASSED **");
    end else begin
      $display("** periodic_tilt_accel_frame_broadcaster: FAILED **");
    end
    $finish;
  end

endmodule
